// ----- rtl/core/qsed_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the quoted string escape decoder.
// No dependencies; used by every module of the core.
package qsed_pkg;

    // Error codes carried with each result
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_HEX  = 2'd1;
    localparam logic [1:0] ERR_OPEN = 2'd2;

    // Characters recognized by the decoder
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CH_X         = 8'h78;

    // Control bytes produced by the letter escapes
    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_HT  = 8'h09;
    localparam logic [7:0] BYTE_VT  = 8'h0B;

    // One result transfer
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
        logic [1:0] err;
    } result_t;

    // One queue entry: the results caused by one input byte
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } cmd_t;

endpackage

// ----- rtl/core/qsed_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks the escape state and turns each
// byte into at most one queue entry of one or two results. Depends on qsed_pkg.
module qsed_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       in_char,
    input  logic             in_last,
    input  logic             queue_room,
    output logic             push,
    output qsed_pkg::cmd_t   push_cmd
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_HEX2   = 3'd3,
        MODE_OCT    = 3'd4,
        MODE_ERR    = 3'd5
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [8:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;

    qsed_pkg::result_t res_a, res_b, res_c, res_second;
    logic a_v, b_v, c_v;
    logic accept;
    logic is_oct;
    logic hex_ok;
    logic [3:0] hex_val;
    logic [8:0] acc_hex, acc_oct;
    logic [1:0] cnt_inc;
    logic open_end;

    function automatic qsed_pkg::result_t mk_res(input logic [7:0] ch, input logic valid,
                                                 input logic [1:0] err);
        qsed_pkg::result_t r;
        r.ch    = valid ? ch : 8'd0;
        r.valid = valid;
        r.last  = 1'b0;
        r.err   = err;
        return r;
    endfunction

    assign s_tready = queue_room;
    assign accept   = s_tvalid && s_tready;
    assign is_oct   = (in_char[7:3] == 5'b00110);
    assign acc_hex  = {acc_reg[4:0], hex_val};
    assign acc_oct  = {acc_reg[5:0], in_char[2:0]};
    assign cnt_inc  = cnt_reg + 2'd1;

    // Hex digit decode, either case
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = in_char[3:0];
        if (in_char >= 8'h30 && in_char <= 8'h39) begin
            hex_val = in_char[3:0];
        end else if ((in_char >= 8'h61 && in_char <= 8'h66) ||
                     (in_char >= 8'h41 && in_char <= 8'h46)) begin
            hex_val = in_char[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        a_v       = 1'b0;
        b_v       = 1'b0;
        res_a     = mk_res(8'd0, 1'b0, qsed_pkg::ERR_NONE);
        res_b     = mk_res(in_char, 1'b1, qsed_pkg::ERR_NONE);
        unique case (mode_reg) inside
            MODE_NORMAL: begin
                if (in_char == qsed_pkg::CH_BACKSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    a_v   = 1'b1;
                    res_a = mk_res(in_char, 1'b1, qsed_pkg::ERR_NONE);
                end
            end
            MODE_ESC: begin
                mode_next = MODE_NORMAL;
                a_v       = 1'b1;
                unique case (in_char) inside
                    qsed_pkg::CH_DQUOTE, qsed_pkg::CH_SQUOTE, qsed_pkg::CH_BACKSLASH:
                        res_a = mk_res(in_char, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_A: res_a = mk_res(qsed_pkg::BYTE_BEL, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_B: res_a = mk_res(qsed_pkg::BYTE_BS, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_F: res_a = mk_res(qsed_pkg::BYTE_FF, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_N: res_a = mk_res(qsed_pkg::BYTE_LF, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_R: res_a = mk_res(qsed_pkg::BYTE_CR, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_T: res_a = mk_res(qsed_pkg::BYTE_HT, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_V: res_a = mk_res(qsed_pkg::BYTE_VT, 1'b1, qsed_pkg::ERR_NONE);
                    qsed_pkg::CH_X: begin
                        a_v       = 1'b0;
                        mode_next = MODE_HEX1;
                    end
                    default: begin
                        a_v = 1'b0;
                        if (is_oct) begin
                            acc_next  = {6'd0, in_char[2:0]};
                            cnt_next  = 2'd1;
                            mode_next = MODE_OCT;
                        end
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2: begin
                if (!hex_ok) begin
                    a_v       = 1'b1;
                    res_a     = mk_res(8'd0, 1'b0, qsed_pkg::ERR_HEX);
                    mode_next = MODE_ERR;
                end else if (mode_reg == MODE_HEX1) begin
                    acc_next  = {5'd0, hex_val};
                    mode_next = MODE_HEX2;
                end else begin
                    acc_next  = acc_hex;
                    a_v       = 1'b1;
                    res_a     = mk_res(acc_hex[7:0], 1'b1, qsed_pkg::ERR_NONE);
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_OCT: begin
                if (is_oct) begin
                    acc_next = acc_oct;
                    cnt_next = cnt_inc;
                    if (cnt_inc == 2'd3) begin
                        a_v       = 1'b1;
                        res_a     = mk_res(acc_oct[7:0], 1'b1, qsed_pkg::ERR_NONE);
                        mode_next = MODE_NORMAL;
                    end
                end else begin
                    // flush the octal value, then handle the byte as in plain character mode
                    a_v       = 1'b1;
                    res_a     = mk_res(acc_reg[7:0], 1'b1, qsed_pkg::ERR_NONE);
                    mode_next = MODE_NORMAL;
                    if (in_char == qsed_pkg::CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        b_v = 1'b1;
                    end
                end
            end
            default: begin
                mode_next = MODE_ERR;
            end
        endcase
    end

    // End-of-string result
    assign open_end = (mode_next == MODE_ESC) || (mode_next == MODE_HEX1) ||
                      (mode_next == MODE_HEX2);
    assign c_v = in_last && ((mode_next == MODE_OCT) || open_end || !a_v);

    always_comb begin
        if (mode_next == MODE_OCT) begin
            res_c = mk_res(acc_next[7:0], 1'b1, qsed_pkg::ERR_NONE);
        end else if (open_end) begin
            res_c = mk_res(8'd0, 1'b0, qsed_pkg::ERR_OPEN);
        end else if (mode_next == MODE_ERR) begin
            res_c = mk_res(8'd0, 1'b0, qsed_pkg::ERR_HEX);
        end else begin
            res_c = mk_res(8'd0, 1'b0, qsed_pkg::ERR_NONE);
        end
        res_second = b_v ? res_b : res_c;
    end

    always_comb begin
        push_cmd.two    = a_v && (b_v || c_v);
        push_cmd.first  = a_v ? res_a : res_c;
        push_cmd.second = res_second;
        if (push_cmd.two) begin
            push_cmd.second.last = in_last;
        end else begin
            push_cmd.first.last = in_last;
        end
        push = accept && (a_v || c_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= 9'd0;
            cnt_reg  <= 2'd0;
        end else if (accept) begin
            if (in_last) begin
                mode_reg <= MODE_NORMAL;
                acc_reg  <= 9'd0;
                cnt_reg  <= 2'd0;
            end else begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

// ----- rtl/core/qsed_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front end and the result stage.
// Depends on qsed_pkg for the entry type.
module qsed_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  qsed_pkg::cmd_t push_cmd,
    input  logic           pop,
    output qsed_pkg::cmd_t head,
    output logic           not_empty,
    output logic           not_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qsed_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/qsed_back.sv -----
`timescale 1ns / 1ps
// Result stage: walks the results of each queue entry into the output
// register. Depends on qsed_pkg.
module qsed_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  qsed_pkg::cmd_t head,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast
);

    logic              sel_reg;
    logic              m_tvalid_reg;
    qsed_pkg::result_t out_reg;
    qsed_pkg::result_t cur;
    logic              load;

    assign load = head_valid && (!m_tvalid_reg || m_tready);
    assign cur  = sel_reg ? head.second : head.first;
    assign pop  = load && (sel_reg || !head.two);

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                sel_reg      <= !pop;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.ch;
    assign m_tuser  = {out_reg.err, out_reg.valid};
    assign m_tlast  = out_reg.last;

endmodule

// ----- rtl/core/quoted_string_escape_decoder_core.sv -----
`timescale 1ns / 1ps
// Top level of the quoted string escape decoder.
// Depends on qsed_pkg, qsed_front, qsed_queue and qsed_back.
//
// Usage:
//   Feed the body of a quoted string (no enclosing quotes) on the s_ channel,
//   one byte per transfer, with s_tlast on the final byte. Decoded bytes come
//   out on the m_ channel, one result per transfer; m_tlast marks the final
//   result of each string, and every string ends with exactly one such result.
//   m_tuser[0] tells whether m_tdata holds a byte; m_tuser[2:1] carries the
//   error code (invalid hex digit, or escape still open at the end).
// Timing:
//   A result passes through the command queue and then the output register
//   before it is presented on the m_ ports. One input byte is taken per
//   cycle while the queue has room. A byte that yields two results (an
//   octal run closed by another byte) sends both through the result stage in
//   turn, so the sustained rate drops only where such bytes occur; the command
//   queue between front end and result stage absorbs short bursts of them.
// Stall and reset:
//   When m_tready is low the output register holds its transfer and the
//   queue fills; s_tready drops once the queue is full. A synchronous reset
//   (aresetn low) empties the queue and output and returns the decoder to
//   plain character mode.
module quoted_string_escape_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_char
    input  logic       s_tlast,    // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic [2:0] m_tuser,    // [0] out_valid, [2:1] out_error
    output logic       m_tlast     // out_end
);

    qsed_pkg::cmd_t push_cmd;
    qsed_pkg::cmd_t head;
    logic           push;
    logic           pop;
    logic           not_empty;
    logic           not_full;

    // Front end: classify each byte and queue the results it causes
    qsed_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .queue_room (not_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Decouple the front end from output stalls
    qsed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    // Result stage: one result transfer per cycle into the output register when not stalled
    qsed_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
